@@ rtl/core/sraf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sraf_pkg
// Shared types and constants of the segmented range frame assembler.
// ----------------------------------------------------------------------------
package sraf_pkg;

  localparam int unsigned ZonesPerSegment = 4;
  localparam int unsigned MaxZonesDef     = 64;
  localparam int unsigned MaxSegmentsDef  = 16;

  localparam int unsigned IdW      = 11;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LaneW    = 16;
  localparam int unsigned RowW     = LaneW * ZonesPerSegment;

  // register index, paddr[3:2]
  localparam logic [1:0] RegHeaderId = 2'd0;
  localparam logic [1:0] RegDataBase = 2'd1;
  localparam logic [1:0] RegDataLast = 2'd2;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  payload_b0;
    logic [7:0]  payload_b1;
    logic [7:0]  payload_b2;
    logic [7:0]  payload_b3;
    logic [7:0]  payload_b4;
    logic [7:0]  payload_b5;
    logic [7:0]  payload_b6;
    logic [7:0]  payload_b7;
  } frame_t;

  typedef struct packed {
    logic [5:0]  zone_index;
    logic [15:0] zone_distance_mm;
    logic [7:0]  measurement_counter;
    logic [6:0]  zone_total;
    logic [7:0]  valid_zones;
    logic [15:0] nearest_distance_mm;
    logic [7:0]  nearest_zone;
    logic [7:0]  sensor_state;
    logic [15:0] completed_count;
    logic        last_zone;
  } zone_result_t;

endpackage
`default_nettype wire

@@ rtl/core/sraf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sraf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sraf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/segmented_range_frame_assembler_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_range_frame_assembler_top
// Rebuilds a segmented range measurement from header and data frames and
// streams one result beat per zone once every segment has arrived.
// ----------------------------------------------------------------------------
// Frames: one beat per cycle while idle; a frame's state update is registered.
// Completion: the completing frame starts a segment RAM read, then the output
//   register load; each later zone is read once the previous beat is taken,
//   then loaded; frames are held off until the last zone beat is taken.
// Reset: clears config, control and header state; the segment RAM is not
//   cleared and needs no clearing pass.
module segmented_range_frame_assembler_top
  import sraf_pkg::*;
#(
  parameter int unsigned MaxZones    = MaxZonesDef,
  parameter int unsigned MaxSegments = MaxSegmentsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire frame_t              in_data_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output zone_result_t             out_data_o,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned SegAw  = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned ZoneAw = $clog2(MaxZones);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StLoad,
    StDrain
  } state_e;

  state_e state_q;

  logic [IdW-1:0] header_id_q, data_base_q, data_last_q;

  logic [MaxSegments-1:0] seg_mask_q;
  logic [4:0]             exp_segs_q;
  logic                   assembling_q;
  logic [7:0]             held_counter_q;
  logic [6:0]             held_zone_total_q;
  logic [7:0]             held_valid_q;
  logic [15:0]            held_near_dist_q;
  logic [7:0]             held_near_zone_q;
  logic [7:0]             held_sensor_state_q;
  logic [15:0]            published_q;
  logic [ZoneAw-1:0]      zone_q;

  zone_result_t out_q;
  logic         out_valid_q;

  // ---- configuration port ----
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegHeaderId: prdata = CfgDataW'(header_id_q);
      RegDataBase: prdata = CfgDataW'(data_base_q);
      RegDataLast: prdata = CfgDataW'(data_last_q);
      default:     prdata = '0;
    endcase
  end

  // ---- frame decode ----
  logic                   in_fire;
  logic                   is_header, hdr_ok, is_data, data_ok, done;
  logic [IdW-1:0]         seg;
  logic [MaxSegments-1:0] seg_bit, mask_next, full_mask;
  logic [RowW-1:0]        row_wdata;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_header = (in_data_i.frame_id == header_id_q);
  assign hdr_ok    = (in_data_i.payload_b1 != 8'd0) &&
                     (in_data_i.payload_b1 <= 8'(MaxZones)) &&
                     (in_data_i.payload_b2 != 8'd0) &&
                     (in_data_i.payload_b2 <= 8'(MaxSegments)) &&
                     ({2'b00, in_data_i.payload_b1} == {in_data_i.payload_b2, 2'b00});

  assign is_data = !is_header && (in_data_i.frame_id >= data_base_q) &&
                   (in_data_i.frame_id <= data_last_q);
  assign seg     = in_data_i.frame_id - data_base_q;
  assign data_ok = is_data && assembling_q && (seg < {6'd0, exp_segs_q}) &&
                   (seg < IdW'(MaxSegments));

  assign seg_bit   = MaxSegments'(1) << seg[SegAw-1:0];
  assign mask_next = seg_mask_q | seg_bit;

  always_comb begin
    for (int j = 0; j < MaxSegments; j++) begin
      full_mask[j] = (5'(j) < exp_segs_q);
    end
  end

  assign done = (mask_next == full_mask);

  assign row_wdata = {in_data_i.payload_b7, in_data_i.payload_b6,
                      in_data_i.payload_b5, in_data_i.payload_b4,
                      in_data_i.payload_b3, in_data_i.payload_b2,
                      in_data_i.payload_b1, in_data_i.payload_b0};

  // ---- segment RAM, one row of four distances per segment ----
  logic              ram_we, ram_re, drain_next;
  logic [ZoneAw-1:0] rd_zone;
  logic [RowW-1:0]   ram_rdata;
  logic              zone_last;

  assign ram_we     = in_fire && data_ok;
  assign drain_next = (state_q == StDrain) && out_ready_i && !out_q.last_zone;
  assign ram_re     = (state_q == StRead) || drain_next;
  assign rd_zone    = drain_next ? ZoneAw'(zone_q + 1'b1) : zone_q;
  assign zone_last  = (7'(zone_q) == (held_zone_total_q - 7'd1));

  sraf_ram #(
    .Width (RowW),
    .Depth (MaxSegments)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seg[SegAw-1:0]),
    .wdata_i (row_wdata),
    .re_i    (ram_re),
    .raddr_i (SegAw'(rd_zone >> 2)),
    .rdata_o (ram_rdata)
  );

  // ---- control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= StIdle;
      header_id_q         <= '0;
      data_base_q         <= '0;
      data_last_q         <= '0;
      seg_mask_q          <= '0;
      exp_segs_q          <= '0;
      assembling_q        <= 1'b0;
      held_counter_q      <= '0;
      held_zone_total_q   <= '0;
      held_valid_q        <= '0;
      held_near_dist_q    <= '0;
      held_near_zone_q    <= '0;
      held_sensor_state_q <= '0;
      published_q         <= '0;
      zone_q              <= '0;
      out_q               <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          RegHeaderId: header_id_q <= pwdata[IdW-1:0];
          RegDataBase: data_base_q <= pwdata[IdW-1:0];
          RegDataLast: data_last_q <= pwdata[IdW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (is_header) begin
              assembling_q <= hdr_ok;
              if (hdr_ok) begin
                held_counter_q      <= in_data_i.payload_b0;
                held_zone_total_q   <= in_data_i.payload_b1[6:0];
                held_valid_q        <= in_data_i.payload_b3;
                held_near_dist_q    <= {in_data_i.payload_b5, in_data_i.payload_b4};
                held_near_zone_q    <= in_data_i.payload_b6;
                held_sensor_state_q <= in_data_i.payload_b7;
                exp_segs_q          <= in_data_i.payload_b2[4:0];
                seg_mask_q          <= '0;
              end
            end else if (data_ok) begin
              seg_mask_q <= mask_next;
              if (done) begin
                published_q  <= published_q + 16'd1;
                assembling_q <= 1'b0;
                zone_q       <= '0;
                state_q      <= StRead;
              end
            end
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          out_q.zone_index          <= 6'(zone_q);
          out_q.zone_distance_mm    <= ram_rdata[LaneW*zone_q[1:0] +: LaneW];
          out_q.measurement_counter <= held_counter_q;
          out_q.zone_total          <= held_zone_total_q;
          out_q.valid_zones         <= held_valid_q;
          out_q.nearest_distance_mm <= held_near_dist_q;
          out_q.nearest_zone        <= held_near_zone_q;
          out_q.sensor_state        <= held_sensor_state_q;
          out_q.completed_count     <= published_q;
          out_q.last_zone           <= zone_last;
          out_valid_q               <= 1'b1;
          state_q                   <= StDrain;
        end
        StDrain: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_q.last_zone) begin
              state_q <= StIdle;
            end else begin
              zone_q  <= ZoneAw'(zone_q + 1'b1);
              state_q <= StLoad;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
